// ----- design/vrft_pkg.sv -----
// shared constants, types and rounding helpers for the vector rotation pipeline
`default_nettype none
package vrft_pkg;

  localparam int FRAC_BITS   = 14;
  localparam int ONE         = 1 << FRAC_BITS;
  localparam int HALF        = 1 << (FRAC_BITS - 1);
  localparam int SQRT_STAGES = 32;
  localparam int DIV_STAGES  = FRAC_BITS + 1;
  localparam int NUM_W       = 32 + FRAC_BITS + 2;
  localparam int BACK_STAGES = 6;
  localparam logic [14:0] EPS_RESET = 15'd16;

  typedef enum logic [1:0] {
    CASE_ROT  = 2'd0,
    CASE_KEEP = 2'd1,
    CASE_FLIP = 2'd2
  } case_t;

  typedef struct {
    logic signed [15:0] v [3];
    logic signed [15:0] c;
    case_t              cs;
    logic signed [32:0] k [3];
  } side_t;

  typedef struct {
    logic signed [15:0] v [3];
    logic signed [15:0] c;
    case_t              cs;
    logic signed [15:0] sn;
    logic signed [15:0] n [3];
  } back_t;

  // drop fraction bits, round half up
  function automatic logic signed [63:0] rnd(input logic signed [63:0] x);
    return (x + 64'(HALF)) >>> FRAC_BITS;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [63:0] x);
    if (x > 64'sd32767) begin
      return 16'sh7fff;
    end else if (x < -64'sd32768) begin
      return 16'sh8000;
    end else begin
      return x[15:0];
    end
  endfunction

endpackage
`default_nettype wire

// ----- design/vector_rotate_from_to.sv -----
// top level: rotate a vector by the rotation taking one direction onto another
// throughput: one item per cycle, busy is never raised
// depth is set by the 32-stage square root and the 15-stage axis divider
// reset (rst_n low, synchronous) clears all valid bits and sets angle_epsilon to 16
// the receiver cannot stall: every result is shown for exactly one cycle
`default_nettype none
module vector_rotate_from_to (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_vec_x,
  input  logic signed [15:0] in_vec_y,
  input  logic signed [15:0] in_vec_z,
  input  logic signed [15:0] in_src_dir_x,
  input  logic signed [15:0] in_src_dir_y,
  input  logic signed [15:0] in_src_dir_z,
  input  logic signed [15:0] in_dst_dir_x,
  input  logic signed [15:0] in_dst_dir_y,
  input  logic signed [15:0] in_dst_dir_z,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [14:0]        cfg_data,
  output logic               out_valid,
  output logic signed [15:0] out_x,
  output logic signed [15:0] out_y,
  output logic signed [15:0] out_z,
  output logic [1:0]         out_case_taken
);
  import vrft_pkg::*;

  localparam int MID = SQRT_STAGES + DIV_STAGES;

  logic [14:0] eps_r;

  logic signed [15:0] v_w [3];
  logic signed [15:0] s_w [3];
  logic signed [15:0] d_w [3];

  // front stages
  logic               vld1_r, vld2_r, vld3_r, vld4_r;
  logic signed [31:0] pd1_r [3];
  logic signed [31:0] pa1_r [3];
  logic signed [31:0] pb1_r [3];
  logic signed [15:0] v1_r [3];
  logic signed [19:0] c2_r;
  logic signed [32:0] k2_r [3];
  logic signed [15:0] v2_r [3];
  case_t              cs3_nxt, cs3_r;
  logic signed [15:0] cc3_nxt, cc3_r;
  logic [28:0]        csq3_nxt, csq3_r;
  logic [63:0]        ksq3_nxt [3];
  logic [63:0]        ksq3_r [3];
  logic signed [32:0] k3_r [3];
  logic signed [15:0] v3_r [3];
  logic [63:0]        sumsq4_r;
  logic [63:0]        snin4_r;
  side_t              side4_r;

  // root and divider section
  logic               vs_r [MID];
  side_t              sd_r [MID];
  logic [31:0]        norm_w;
  logic [31:0]        snroot_w;
  logic [15:0]        snd_r [DIV_STAGES];
  logic               nzd_r [DIV_STAGES];
  logic [NUM_W-1:0]   num_w [3];
  logic [DIV_STAGES-1:0] quo_w [3];
  back_t              back_nxt;

  // back stages
  logic               vb_r [BACK_STAGES];
  back_t              bk_r [BACK_STAGES];
  logic signed [31:0] pnv2_r [3];
  logic signed [31:0] ta2_r [3];
  logic signed [31:0] tb2_r [3];
  logic signed [19:0] a13_r;
  logic signed [19:0] t3_r [3];
  logic signed [17:0] omc3_r;
  logic signed [19:0] t4_r [3];
  logic signed [19:0] t5_r [3];
  logic signed [37:0] pa4_r;
  logic signed [23:0] a5_r;
  logic signed [39:0] pna6_r [3];
  logic signed [31:0] pvc6_r [3];
  logic signed [35:0] pts6_r [3];

  logic               out_valid_r;
  logic signed [15:0] out_r [3];
  case_t              out_cs_r;
  logic signed [15:0] res_nxt [3];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  assign v_w[0] = in_vec_x;
  assign v_w[1] = in_vec_y;
  assign v_w[2] = in_vec_z;
  assign s_w[0] = in_src_dir_x;
  assign s_w[1] = in_src_dir_y;
  assign s_w[2] = in_src_dir_z;
  assign d_w[0] = in_dst_dir_x;
  assign d_w[1] = in_dst_dir_y;
  assign d_w[2] = in_dst_dir_z;

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= EPS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      eps_r <= cfg_data;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r      <= 1'b0;
      vld2_r      <= 1'b0;
      vld3_r      <= 1'b0;
      vld4_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MID; i++) begin
        vs_r[i] <= 1'b0;
      end
      for (int i = 0; i < BACK_STAGES; i++) begin
        vb_r[i] <= 1'b0;
      end
    end else begin
      vld1_r <= start && !busy;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
      vld4_r <= vld3_r;
      vs_r[0] <= vld4_r;
      for (int i = 1; i < MID; i++) begin
        vs_r[i] <= vs_r[i-1];
      end
      vb_r[0] <= vs_r[MID-1];
      for (int i = 1; i < BACK_STAGES; i++) begin
        vb_r[i] <= vb_r[i-1];
      end
      out_valid_r <= vb_r[BACK_STAGES-1];
    end
  end

  // case decision, clamp and squares
  always_comb begin
    logic signed [21:0] dp;
    logic signed [21:0] dm;
    logic signed [32:0] kn;
    logic [31:0]        kabs;
    logic signed [31:0] cq;
    dp = 22'(c2_r) - 22'(ONE);
    dm = 22'(c2_r) + 22'(ONE);
    if (dp < 0) begin
      dp = -dp;
    end
    if (dm < 0) begin
      dm = -dm;
    end
    if (dp < $signed({7'b0, eps_r})) begin
      cs3_nxt = CASE_KEEP;
    end else if (dm < $signed({7'b0, eps_r})) begin
      cs3_nxt = CASE_FLIP;
    end else begin
      cs3_nxt = CASE_ROT;
    end
    if (c2_r > 20'(ONE)) begin
      cc3_nxt = 16'(ONE);
    end else if (c2_r < -20'(ONE)) begin
      cc3_nxt = -16'(ONE);
    end else begin
      cc3_nxt = c2_r[15:0];
    end
    cq = 32'(cc3_nxt) * 32'(cc3_nxt);
    csq3_nxt = cq[28:0];
    for (int i = 0; i < 3; i++) begin
      kn = (k2_r[i] < 0) ? -k2_r[i] : k2_r[i];
      kabs = kn[31:0];
      ksq3_nxt[i] = 64'(kabs) * 64'(kabs);
    end
  end

  // front payload
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      pd1_r[i] <= s_w[i] * d_w[i];
      v1_r[i]  <= v_w[i];
      k2_r[i]  <= 33'(pa1_r[i]) - 33'(pb1_r[i]);
      v2_r[i]  <= v1_r[i];
      ksq3_r[i] <= ksq3_nxt[i];
      k3_r[i]  <= k2_r[i];
      v3_r[i]  <= v2_r[i];
      side4_r.v[i] <= v3_r[i];
      side4_r.k[i] <= k3_r[i];
    end
    pa1_r[0] <= s_w[1] * d_w[2];
    pb1_r[0] <= s_w[2] * d_w[1];
    pa1_r[1] <= s_w[2] * d_w[0];
    pb1_r[1] <= s_w[0] * d_w[2];
    pa1_r[2] <= s_w[0] * d_w[1];
    pb1_r[2] <= s_w[1] * d_w[0];
    c2_r <= 20'(rnd(64'(pd1_r[0]) + 64'(pd1_r[1]) + 64'(pd1_r[2])));
    cs3_r  <= cs3_nxt;
    cc3_r  <= cc3_nxt;
    csq3_r <= csq3_nxt;
    sumsq4_r <= ksq3_r[0] + ksq3_r[1] + ksq3_r[2];
    snin4_r  <= (64'd1 << (2 * FRAC_BITS)) - 64'(csq3_r);
    side4_r.c  <= cc3_r;
    side4_r.cs <= cs3_r;
  end

  vrft_isqrt u_norm_sqrt (
    .clk    (clk),
    .rad_i  (sumsq4_r),
    .root_o (norm_w)
  );

  vrft_isqrt u_sin_sqrt (
    .clk    (clk),
    .rad_i  (snin4_r),
    .root_o (snroot_w)
  );

  for (genvar g = 0; g < 3; g++) begin : g_axis
    logic signed [32:0] kn;
    logic [31:0]        mag;
    assign kn  = (sd_r[SQRT_STAGES-1].k[g] < 0) ? -sd_r[SQRT_STAGES-1].k[g]
                                                 : sd_r[SQRT_STAGES-1].k[g];
    assign mag = kn[31:0];
    assign num_w[g] = (NUM_W'(mag) << FRAC_BITS) + NUM_W'(norm_w >> 1);
    vrft_div u_div (
      .clk   (clk),
      .num_i (num_w[g]),
      .den_i (norm_w),
      .quo_o (quo_w[g])
    );
  end

  // side data and sine through the root and divider
  always_ff @(posedge clk) begin
    sd_r[0] <= side4_r;
    for (int i = 1; i < MID; i++) begin
      sd_r[i] <= sd_r[i-1];
    end
    snd_r[0] <= snroot_w[15:0];
    nzd_r[0] <= (norm_w == '0);
    for (int i = 1; i < DIV_STAGES; i++) begin
      snd_r[i] <= snd_r[i-1];
      nzd_r[i] <= nzd_r[i-1];
    end
  end

  // signed axis from quotient
  always_comb begin
    logic signed [15:0] q;
    back_nxt.v  = sd_r[MID-1].v;
    back_nxt.c  = sd_r[MID-1].c;
    back_nxt.cs = sd_r[MID-1].cs;
    back_nxt.sn = $signed(snd_r[DIV_STAGES-1]);
    for (int i = 0; i < 3; i++) begin
      q = $signed(16'(quo_w[i]));
      if (nzd_r[DIV_STAGES-1]) begin
        back_nxt.n[i] = '0;
      end else if (sd_r[MID-1].k[i] < 0) begin
        back_nxt.n[i] = -q;
      end else begin
        back_nxt.n[i] = q;
      end
    end
  end

  // rodrigues combine
  always_ff @(posedge clk) begin
    bk_r[0] <= back_nxt;
    for (int i = 1; i < BACK_STAGES; i++) begin
      bk_r[i] <= bk_r[i-1];
    end
    for (int i = 0; i < 3; i++) begin
      pnv2_r[i] <= bk_r[0].n[i] * bk_r[0].v[i];
      t3_r[i]   <= 20'(rnd(64'(ta2_r[i]) - 64'(tb2_r[i])));
      t4_r[i]   <= t3_r[i];
      t5_r[i]   <= t4_r[i];
      pna6_r[i] <= 40'(bk_r[4].n[i]) * 40'(a5_r);
      pvc6_r[i] <= bk_r[4].v[i] * bk_r[4].c;
      pts6_r[i] <= 36'(t5_r[i]) * 36'(bk_r[4].sn);
    end
    ta2_r[0] <= bk_r[0].n[1] * bk_r[0].v[2];
    tb2_r[0] <= bk_r[0].n[2] * bk_r[0].v[1];
    ta2_r[1] <= bk_r[0].n[2] * bk_r[0].v[0];
    tb2_r[1] <= bk_r[0].n[0] * bk_r[0].v[2];
    ta2_r[2] <= bk_r[0].n[0] * bk_r[0].v[1];
    tb2_r[2] <= bk_r[0].n[1] * bk_r[0].v[0];
    a13_r  <= 20'(rnd(64'(pnv2_r[0]) + 64'(pnv2_r[1]) + 64'(pnv2_r[2])));
    omc3_r <= 18'(ONE) - 18'(bk_r[1].c);
    pa4_r  <= 38'(a13_r) * 38'(omc3_r);
    a5_r   <= 24'(rnd(64'(pa4_r)));
  end

  // final round, saturate and case select
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      case (bk_r[BACK_STAGES-1].cs)
        CASE_KEEP: res_nxt[i] = bk_r[BACK_STAGES-1].v[i];
        CASE_FLIP: res_nxt[i] = sat16(-64'(bk_r[BACK_STAGES-1].v[i]));
        default:   res_nxt[i] = sat16(rnd(64'(pna6_r[i]) + 64'(pvc6_r[i])
                                          + 64'(pts6_r[i])));
      endcase
    end
  end

  always_ff @(posedge clk) begin
    out_r    <= res_nxt;
    out_cs_r <= bk_r[BACK_STAGES-1].cs;
  end

  assign out_valid      = out_valid_r;
  assign out_x          = out_r[0];
  assign out_y          = out_r[1];
  assign out_z          = out_r[2];
  assign out_case_taken = out_cs_r;

endmodule
`default_nettype wire

// ----- design/vrft_isqrt.sv -----
// pipelined floor square root of a 64-bit value, one result bit per stage
`default_nettype none
module vrft_isqrt (
  input  logic        clk,
  input  logic [63:0] rad_i,
  output logic [31:0] root_o
);
  import vrft_pkg::*;

  logic [63:0] rem_r [SQRT_STAGES];
  logic [63:0] res_r [SQRT_STAGES];

  for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stage
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * g);
    logic [63:0] rem_in;
    logic [63:0] res_in;
    logic [63:0] trial;
    if (g == 0) begin : g_first
      assign rem_in = rad_i;
      assign res_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[g-1];
      assign res_in = res_r[g-1];
    end
    assign trial = res_in + BIT;
    always_ff @(posedge clk) begin
      if (rem_in >= trial) begin
        rem_r[g] <= rem_in - trial;
        res_r[g] <= (res_in >> 1) + BIT;
      end else begin
        rem_r[g] <= rem_in;
        res_r[g] <= res_in >> 1;
      end
    end
  end

  assign root_o = res_r[SQRT_STAGES-1][31:0];

endmodule
`default_nettype wire

// ----- design/vrft_div.sv -----
// pipelined restoring divider, one quotient bit per stage
`default_nettype none
module vrft_div (
  input  logic                             clk,
  input  logic [vrft_pkg::NUM_W-1:0]       num_i,
  input  logic [31:0]                      den_i,
  output logic [vrft_pkg::DIV_STAGES-1:0]  quo_o
);
  import vrft_pkg::*;

  logic [NUM_W-1:0]      rem_r [DIV_STAGES];
  logic [31:0]           den_r [DIV_STAGES];
  logic [DIV_STAGES-1:0] quo_r [DIV_STAGES];

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    logic [NUM_W-1:0]      rem_in;
    logic [31:0]           den_in;
    logic [DIV_STAGES-1:0] quo_in;
    logic [NUM_W-1:0]      dsh;
    if (g == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[g-1];
      assign den_in = den_r[g-1];
      assign quo_in = quo_r[g-1];
    end
    assign dsh = NUM_W'(den_in) << (DIV_STAGES - 1 - g);
    always_ff @(posedge clk) begin
      den_r[g] <= den_in;
      if (rem_in >= dsh) begin
        rem_r[g] <= rem_in - dsh;
        quo_r[g] <= {quo_in[DIV_STAGES-2:0], 1'b1};
      end else begin
        rem_r[g] <= rem_in;
        quo_r[g] <= {quo_in[DIV_STAGES-2:0], 1'b0};
      end
    end
  end

  assign quo_o = quo_r[DIV_STAGES-1];

endmodule
`default_nettype wire
